[design/cqmm_pkg.sv]
// Shared constants, codes, helpers and controller/datapath interface types.
package cqmm_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W = 4;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_ENQ   = 2'd1;
  localparam logic [1:0] KIND_DEQ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic capture;     // latch the input transfer, read the head slot
    logic op_exec;     // apply enqueue or dequeue
    logic walk_start;  // seed the ring walk at the head slot
    logic walk_step;   // fold one stored entry into front/min/max
    logic out_load;    // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;    // queue holds no entries
    logic walk_last;   // current walk step consumes the last entry
    logic out_free;    // output register can take a result this cycle
  } stat_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

[design/cqmm_ctrl.sv]
// Sequencer for the queue operation, ring walk and result handoff.
module cqmm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cqmm_pkg::stat_t stat,
  output cqmm_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_START,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_OP;
      end
      S_OP: begin
        cmd.op_exec = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.walk_start = 1'b1;
        state_nxt      = stat.cnt_zero ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        cmd.out_load = stat.out_free;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/cqmm_dp.sv]
// Datapath: entry store, ring pointers, min/max walk and output register.
module cqmm_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cqmm_pkg::cmd_t                     cmd,
  output cqmm_pkg::stat_t                    stat,
  input  logic [1:0]                         in_kind,
  input  logic signed [cqmm_pkg::WORD_W-1:0] in_value_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_popped_value,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_front_value,
  output logic [cqmm_pkg::OCC_W-1:0]         out_occupancy,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_smallest_value,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_largest_value
);

  logic signed [cqmm_pkg::WORD_W-1:0] mem [cqmm_pkg::DEPTH];
  logic signed [cqmm_pkg::WORD_W-1:0] rd_data_r;
  logic [cqmm_pkg::IDX_W-1:0]         rd_addr;

  logic [1:0]                         kind_r;
  logic signed [cqmm_pkg::WORD_W-1:0] value_r;
  logic [cqmm_pkg::IDX_W-1:0]         head_r, tail_r, walk_ptr_r;
  logic [cqmm_pkg::CNT_W-1:0]         cnt_r, left_r;
  logic                               first_r;
  logic [1:0]                         st_r;
  logic signed [cqmm_pkg::WORD_W-1:0] pop_r, front_r, lo_r, hi_r;
  logic signed [cqmm_pkg::WORD_W-1:0] lo_nxt, hi_nxt;
  logic                               out_valid_r;
  logic [1:0]                         out_status_r;
  logic signed [cqmm_pkg::WORD_W-1:0] out_pop_r, out_front_r, out_lo_r, out_hi_r;
  logic [cqmm_pkg::OCC_W-1:0]         out_occ_r;
  logic                               is_full;

  assign is_full = (cnt_r == cqmm_pkg::CNT_W'(cqmm_pkg::DEPTH));
  assign rd_addr = cmd.walk_step ? walk_ptr_r : head_r;

  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.walk_last = (left_r == cqmm_pkg::CNT_W'(1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // Entry store: one write port at the tail, one registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (cmd.op_exec && kind_r == cqmm_pkg::KIND_ENQ && !is_full) begin
      mem[tail_r] <= value_r;
    end
  end

  always_comb begin
    if (first_r) begin
      lo_nxt = rd_data_r;
      hi_nxt = rd_data_r;
    end else begin
      lo_nxt = (rd_data_r < lo_r) ? rd_data_r : lo_r;
      hi_nxt = (rd_data_r > hi_r) ? rd_data_r : hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op_exec) begin
        if (kind_r == cqmm_pkg::KIND_ENQ && !is_full) begin
          tail_r <= cqmm_pkg::next_slot(tail_r);
          cnt_r  <= cnt_r + 1'b1;
        end else if (kind_r == cqmm_pkg::KIND_DEQ && cnt_r != '0) begin
          head_r <= cqmm_pkg::next_slot(head_r);
          cnt_r  <= cnt_r - 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      value_r <= in_value_in;
    end
    if (cmd.op_exec) begin
      st_r  <= cqmm_pkg::ST_OK;
      pop_r <= '0;
      if (kind_r == cqmm_pkg::KIND_ENQ && is_full) begin
        st_r <= cqmm_pkg::ST_FULL;
      end else if (kind_r == cqmm_pkg::KIND_DEQ) begin
        if (cnt_r == '0) begin
          st_r <= cqmm_pkg::ST_EMPTY;
        end else begin
          pop_r <= rd_data_r;
        end
      end
    end
    if (cmd.walk_start) begin
      walk_ptr_r <= cqmm_pkg::next_slot(head_r);
      left_r     <= cnt_r;
      first_r    <= 1'b1;
      front_r    <= '0;
      lo_r       <= '0;
      hi_r       <= '0;
    end else if (cmd.walk_step) begin
      walk_ptr_r <= cqmm_pkg::next_slot(walk_ptr_r);
      left_r     <= left_r - 1'b1;
      first_r    <= 1'b0;
      if (first_r) front_r <= rd_data_r;
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= st_r;
      out_pop_r    <= pop_r;
      out_front_r  <= front_r;
      out_occ_r    <= cqmm_pkg::OCC_W'(cnt_r);
      out_lo_r     <= lo_r;
      out_hi_r     <= hi_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_popped_value   = out_pop_r;
  assign out_front_value    = out_front_r;
  assign out_occupancy      = out_occ_r;
  assign out_smallest_value = out_lo_r;
  assign out_largest_value  = out_hi_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cqmm_pkg::CNT_W'(cqmm_pkg::DEPTH))
    else $error("occupancy beyond depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || is_full) |-> head_r == tail_r)
    else $error("head and tail disagree with occupancy");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op_exec && kind_r == cqmm_pkg::KIND_ENQ && is_full) |=> cnt_r == $past(cnt_r))
    else $error("rejected enqueue changed occupancy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending transfer");

endmodule

[design/circular_queue_min_max_core.sv]
// Top level of the circular queue with front, occupancy, min and max reporting.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in_     | input     | in_valid / in_ready    | in_kind, in_value_in
//  out_    | output    | out_valid / out_ready  | out_status, out_popped_value,
//          |           |                        | out_front_value, out_occupancy,
//          |           |                        | out_smallest_value, out_largest_value
//
// An item holds the block until it is done: capture it and read the head slot,
// apply the operation, seed the walk, fold one stored entry per cycle through the single
// read port, and load the output once the output register is free.
// rst_n is synchronous, active low: pointers, count and output valid clear, entries stay unwritten.
// A result waiting on out_ready does not block the next input transfer; only the load step
// of a later item holds while that result is still pending.
module circular_queue_min_max_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic signed [cqmm_pkg::WORD_W-1:0] in_value_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_popped_value,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_front_value,
  output logic [cqmm_pkg::OCC_W-1:0]         out_occupancy,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_smallest_value,
  output logic signed [cqmm_pkg::WORD_W-1:0] out_largest_value
);

  // commands flow from the sequencer, status flows back
  cqmm_pkg::cmd_t  cmd;
  cqmm_pkg::stat_t stat;

  cqmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // store, pointers, walk accumulators and the output register
  cqmm_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_kind),
    .in_value_in        (in_value_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_popped_value   (out_popped_value),
    .out_front_value    (out_front_value),
    .out_occupancy      (out_occupancy),
    .out_smallest_value (out_smallest_value),
    .out_largest_value  (out_largest_value)
  );

endmodule
